// File: rtl/core/tdcp_pkg.sv
package tdcp_pkg;

	localparam logic [4:0] TYPE_MEAS = 5'h00;
	localparam logic [4:0] TYPE_THDR = 5'h01;
	localparam logic [4:0] TYPE_TTRL = 5'h03;
	localparam logic [4:0] TYPE_TERR = 5'h04;
	localparam logic [4:0] TYPE_GHDR = 5'h08;
	localparam logic [4:0] TYPE_GTRL = 5'h10;
	localparam logic [4:0] TYPE_ETT  = 5'h11;

	localparam logic KIND_HIT   = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	localparam logic [15:0] WORD_INDEX_MAX = 16'hFFFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_MEAS,
		OP_THDR,
		OP_TTRL,
		OP_TERR,
		OP_GHDR,
		OP_GTRL,
		OP_ETT,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [26:0] data;
	} entry_t;

endpackage

// File: rtl/core/tdcp_front.sv
module tdcp_front (
	input  logic           word_valid,
	input  logic [31:0]    word,
	input  logic           full,
	output logic           word_stall,
	output logic           push,
	output tdcp_pkg::entry_t push_data
);
	import tdcp_pkg::*;

	logic [4:0] wtype;

	assign wtype      = word[31:27];
	assign word_stall = full;
	assign push       = word_valid && !full;

	always_comb begin
		push_data.data = word[26:0];
		case (wtype)
			TYPE_MEAS: push_data.op = OP_MEAS;
			TYPE_THDR: push_data.op = OP_THDR;
			TYPE_TTRL: push_data.op = OP_TTRL;
			TYPE_TERR: push_data.op = OP_TERR;
			TYPE_GHDR: push_data.op = OP_GHDR;
			TYPE_GTRL: push_data.op = OP_GTRL;
			TYPE_ETT:  push_data.op = OP_ETT;
			default:   push_data.op = OP_BAD;
		endcase
	end

endmodule

// File: rtl/core/tdcp_queue.sv
module tdcp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tdcp_pkg::entry_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output tdcp_pkg::entry_t q_data
);
	import tdcp_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0]   wr_ptr_q;
	logic [QIDX_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/tdcp_back.sv
module tdcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tdcp_pkg::entry_t q_data,
	output logic             pop,
	output logic             rec_valid,
	input  logic             rec_stall,
	output logic             kind,
	output logic             trailing_edge,
	output logic [6:0]       channel,
	output logic [18:0]      measurement,
	output logic [21:0]      event_number,
	output logic [4:0]       geo_address,
	output logic             event_error,
	output logic             trigger_lost,
	output logic             buffer_overflow,
	output logic [15:0]      trailer_words,
	output logic [26:0]      trigger_time
);
	import tdcp_pkg::*;

	logic [21:0] event_count_q;
	logic [4:0]  geo_q;
	logic [11:0] header_id_q;
	logic [26:0] trig_time_q;
	logic        error_q;
	logic [15:0] word_index_q;
	logic        rec_valid_q;

	logic        out_free;
	logic        emit;
	logic [26:0] d;
	logic [16:0] count_with_this;
	logic        trailer_error;
	logic [15:0] word_index_inc;

	assign d               = q_data.data;
	assign out_free        = !rec_valid_q || !rec_stall;
	assign pop             = q_valid && out_free;
	assign emit            = (q_data.op == OP_MEAS) || (q_data.op == OP_GTRL);
	assign count_with_this = {1'b0, word_index_q} + 17'd1;
	assign trailer_error   = error_q || d[24] || (d[4:0] != geo_q)
		|| ({1'b0, d[20:5]} != count_with_this);
	assign word_index_inc  = (word_index_q != WORD_INDEX_MAX) ? word_index_q + 16'd1
		: word_index_q;
	assign rec_valid       = rec_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_count_q <= '0;
			geo_q         <= '0;
			header_id_q   <= '0;
			trig_time_q   <= '0;
			error_q       <= 1'b0;
			word_index_q  <= '0;
			rec_valid_q   <= 1'b0;
		end else begin
			if (out_free) begin
				rec_valid_q <= pop && emit;
			end
			if (pop) begin
				word_index_q <= word_index_inc;
				case (q_data.op)
					OP_GHDR: begin
						event_count_q <= d[26:5];
						geo_q         <= d[4:0];
					end
					OP_THDR: begin
						header_id_q <= d[23:12];
					end
					OP_TTRL: begin
						if (d[23:12] != header_id_q) begin
							error_q <= 1'b1;
						end
					end
					OP_TERR: begin
						if (d[11:0] != 12'd0) begin
							error_q <= 1'b1;
						end
					end
					OP_ETT: begin
						trig_time_q <= d;
					end
					OP_GTRL: begin
						event_count_q <= '0;
						geo_q         <= '0;
						error_q       <= 1'b0;
						word_index_q  <= '0;
					end
					OP_BAD: begin
						error_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			if (q_data.op == OP_MEAS) begin
				kind            <= KIND_HIT;
				trailing_edge   <= d[26];
				channel         <= d[25:19];
				measurement     <= d[18:0];
				event_number    <= '0;
				geo_address     <= '0;
				event_error     <= 1'b0;
				trigger_lost    <= 1'b0;
				buffer_overflow <= 1'b0;
				trailer_words   <= '0;
				trigger_time    <= '0;
			end else begin
				kind            <= KIND_EVENT;
				trailing_edge   <= 1'b0;
				channel         <= '0;
				measurement     <= '0;
				event_number    <= event_count_q;
				geo_address     <= geo_q;
				event_error     <= trailer_error;
				trigger_lost    <= d[26];
				buffer_overflow <= d[25];
				trailer_words   <= d[20:5];
				trigger_time    <= trig_time_q;
			end
		end
	end

	a_trailer_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_data.op == OP_GTRL |=> word_index_q == '0 && !error_q && geo_q == '0)
		else $error("per-event state not cleared after a global trailer");

	a_index_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_data.op != OP_GTRL |=> word_index_q >= $past(word_index_q))
		else $error("word index went backwards inside an event");

	a_hit_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && kind == KIND_HIT |-> event_number == '0 && trailer_words == '0
			&& !event_error && trigger_time == '0)
		else $error("hit record carries event fields");

	a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && rec_stall |-> !pop)
		else $error("queue popped while the output register is held");

endmodule

// File: rtl/core/tdc_readout_word_parser_unit.sv
// Readout word parser for a multihit TDC data stream.
// Input channel: word with word_valid and word_stall. A request moves when
// word_valid is high and word_stall is low. Each word is decoded by its type.
// Output channel: one record per measurement word (hit record) and one per
// global trailer (end-of-event record), with rec_valid and rec_stall.
// All other word types only update the event state and give no record.
// A taken word is first written into the queue; when it is popped, its record
// is written into the output register, which drives rec_valid.
// Throughput: one word per cycle, sustained, as long as records are taken.
// A two-entry queue sits between the decode front and the execution back;
// when rec_stall holds the output register, the queue fills and word_stall
// rises once both entries are in use, so no request is lost.
// Reset (arst_n low) empties the queue and the output register and clears all
// event state, trigger time and TDC header event id.
module tdc_readout_word_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [31:0] word,
	output logic        rec_valid,
	input  logic        rec_stall,
	output logic        kind,
	output logic        trailing_edge,
	output logic [6:0]  channel,
	output logic [18:0] measurement,
	output logic [21:0] event_number,
	output logic [4:0]  geo_address,
	output logic        event_error,
	output logic        trigger_lost,
	output logic        buffer_overflow,
	output logic [15:0] trailer_words,
	output logic [26:0] trigger_time
);
	import tdcp_pkg::*;

	logic   full;
	logic   push;
	entry_t push_data;
	logic   pop;
	logic   q_valid;
	entry_t q_data;

	tdcp_front u_front (
		.word_valid (word_valid),
		.word       (word),
		.full       (full),
		.word_stall (word_stall),
		.push       (push),
		.push_data  (push_data)
	);

	tdcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	tdcp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_data          (q_data),
		.pop             (pop),
		.rec_valid       (rec_valid),
		.rec_stall       (rec_stall),
		.kind            (kind),
		.trailing_edge   (trailing_edge),
		.channel         (channel),
		.measurement     (measurement),
		.event_number    (event_number),
		.geo_address     (geo_address),
		.event_error     (event_error),
		.trigger_lost    (trigger_lost),
		.buffer_overflow (buffer_overflow),
		.trailer_words   (trailer_words),
		.trigger_time    (trigger_time)
	);

endmodule
